>>> hw/rtl/qwf_pkg.sv
`timescale 1ns / 1ps

package qwf_pkg;

    localparam int NORM_W    = 30;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIND_DIR_X    = 2'd0,
        CFG_WIND_DIR_Y    = 2'd1,
        CFG_WIND_DIR_Z    = 2'd2,
        CFG_WIND_STRENGTH = 2'd3
    } cfg_idx_t;

endpackage

>>> hw/rtl/qwf_if.sv
`timescale 1ns / 1ps

interface qwf_in_if #(parameter int COORD_WIDTH = 32);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] p1_x;
    logic signed [COORD_WIDTH-1:0] p1_y;
    logic signed [COORD_WIDTH-1:0] p1_z;
    logic signed [COORD_WIDTH-1:0] p2_x;
    logic signed [COORD_WIDTH-1:0] p2_y;
    logic signed [COORD_WIDTH-1:0] p2_z;
    logic signed [COORD_WIDTH-1:0] p3_x;
    logic signed [COORD_WIDTH-1:0] p3_y;
    logic signed [COORD_WIDTH-1:0] p3_z;
    logic signed [COORD_WIDTH-1:0] p4_x;
    logic signed [COORD_WIDTH-1:0] p4_y;
    logic signed [COORD_WIDTH-1:0] p4_z;

    modport source (output valid, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z,
                    p3_x, p3_y, p3_z, p4_x, p4_y, p4_z, input ready);
    modport sink (input valid, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z,
                  p3_x, p3_y, p3_z, p4_x, p4_y, p4_z, output ready);
endinterface

interface qwf_out_if #(parameter int COORD_WIDTH = 32);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] force_x;
    logic signed [COORD_WIDTH-1:0] force_y;
    logic signed [COORD_WIDTH-1:0] force_z;

    modport source (output valid, force_x, force_y, force_z, input ready);
    modport sink (input valid, force_x, force_y, force_z, output ready);
endinterface

>>> hw/rtl/qwf_norm.sv
`timescale 1ns / 1ps

module qwf_norm #(
    parameter int IN_W = 33,
    parameter int FRAC = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic                   in_valid,
    input  logic signed [IN_W-1:0] c [3],
    output logic                   out_valid,
    output logic signed [FRAC+1:0] n [3]
);
    localparam int NW    = qwf_pkg::NORM_W;
    localparam int NTOP  = NW - 1;
    localparam int MSB_W = $clog2(IN_W);
    localparam int SW    = 2 * NW + 4;
    localparam int SQ_N  = NW + 2;
    localparam int RW    = NW + 1;
    localparam int DV_N  = FRAC + 1;
    localparam int DW    = NW + FRAC + 1;
    localparam int QW    = FRAC + 1;
    localparam int UW    = FRAC + 2;

    logic [IN_W-1:0]   a_mag_reg [3];
    logic [2:0]        a_neg_reg;
    logic              a_v_reg;
    logic [IN_W-1:0]   b_mag_reg [3];
    logic [2:0]        b_neg_reg;
    logic [IN_W-1:0]   b_max_reg;
    logic              b_v_reg;
    logic [IN_W-1:0]   c_mag_reg [3];
    logic [2:0]        c_neg_reg;
    logic [MSB_W-1:0]  c_msb_reg;
    logic              c_zero_reg;
    logic              c_v_reg;
    logic [NW-1:0]     d_u_reg [3];
    logic [2:0]        d_neg_reg;
    logic              d_zero_reg;
    logic              d_v_reg;
    logic [2*NW-1:0]   e_sq_reg [3];
    logic [NW-1:0]     e_u_reg [3];
    logic [2:0]        e_neg_reg;
    logic              e_zero_reg;
    logic              e_v_reg;

    logic [SW-1:0]     sq_rem_reg [0:SQ_N];
    logic [SW-1:0]     sq_res_reg [0:SQ_N];
    logic [NW-1:0]     sq_u_reg [0:SQ_N][3];
    logic [2:0]        sq_neg_reg [0:SQ_N];
    logic              sq_zero_reg [0:SQ_N];
    logic              sq_v_reg [0:SQ_N];
    logic [SW-1:0]     sq_rem_next [0:SQ_N-1];
    logic [SW-1:0]     sq_res_next [0:SQ_N-1];
    logic [SW-1:0]     sq_bit [0:SQ_N-1];

    logic [DW-1:0]     dv_rem_reg [0:DV_N][3];
    logic [QW-1:0]     dv_q_reg [0:DV_N][3];
    logic [RW-1:0]     dv_r_reg [0:DV_N];
    logic [2:0]        dv_neg_reg [0:DV_N];
    logic              dv_zero_reg [0:DV_N];
    logic              dv_v_reg [0:DV_N];
    logic [DW-1:0]     dv_rem_next [0:DV_N-1][3];
    logic [QW-1:0]     dv_q_next [0:DV_N-1][3];
    logic [DW-1:0]     dv_try [0:DV_N-1];

    logic signed [UW-1:0] n_reg [3];
    logic                 o_v_reg;

    logic [IN_W-1:0]      mag_next [3];
    logic [2:0]           neg_next;
    logic [IN_W-1:0]      max_next;
    logic [MSB_W-1:0]     msb_next;
    logic [IN_W+NW-1:0]   shift_tmp [3];
    logic signed [UW-1:0] n_next [3];
    logic signed [UW-1:0] q_s [3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            neg_next[k] = c[k][IN_W-1];
            mag_next[k] = neg_next[k] ? IN_W'(-c[k]) : IN_W'(c[k]);
        end
        max_next = a_mag_reg[0];
        if (a_mag_reg[1] > max_next)
        begin
            max_next = a_mag_reg[1];
        end
        if (a_mag_reg[2] > max_next)
        begin
            max_next = a_mag_reg[2];
        end
        msb_next = '0;
        for (int i = 0; i < IN_W; i++)
        begin
            if (b_max_reg[i])
            begin
                msb_next = MSB_W'(i);
            end
        end
        for (int k = 0; k < 3; k++)
        begin
            if (int'(c_msb_reg) > NTOP)
            begin
                shift_tmp[k] = (IN_W+NW)'(c_mag_reg[k]) >> (int'(c_msb_reg) - NTOP);
            end
            else
            begin
                shift_tmp[k] = (IN_W+NW)'(c_mag_reg[k]) << (NTOP - int'(c_msb_reg));
            end
        end
        for (int i = 0; i < SQ_N; i++)
        begin
            sq_bit[i] = SW'(1) << (2 * (SQ_N - 1 - i));
            if (sq_rem_reg[i] >= sq_res_reg[i] + sq_bit[i])
            begin
                sq_rem_next[i] = sq_rem_reg[i] - (sq_res_reg[i] + sq_bit[i]);
                sq_res_next[i] = (sq_res_reg[i] >> 1) + sq_bit[i];
            end
            else
            begin
                sq_rem_next[i] = sq_rem_reg[i];
                sq_res_next[i] = sq_res_reg[i] >> 1;
            end
        end
        for (int j = 0; j < DV_N; j++)
        begin
            dv_try[j] = DW'(dv_r_reg[j]) << (FRAC - j);
            for (int k = 0; k < 3; k++)
            begin
                if (dv_rem_reg[j][k] >= dv_try[j])
                begin
                    dv_rem_next[j][k] = dv_rem_reg[j][k] - dv_try[j];
                    dv_q_next[j][k]   = dv_q_reg[j][k] | (QW'(1) << (FRAC - j));
                end
                else
                begin
                    dv_rem_next[j][k] = dv_rem_reg[j][k];
                    dv_q_next[j][k]   = dv_q_reg[j][k];
                end
            end
        end
        for (int k = 0; k < 3; k++)
        begin
            q_s[k] = $signed({1'b0, dv_q_reg[DV_N][k]});
            if (dv_zero_reg[DV_N])
            begin
                n_next[k] = '0;
            end
            else if (dv_neg_reg[DV_N][k])
            begin
                n_next[k] = -q_s[k];
            end
            else
            begin
                n_next[k] = q_s[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg <= 1'b0;
            b_v_reg <= 1'b0;
            c_v_reg <= 1'b0;
            d_v_reg <= 1'b0;
            e_v_reg <= 1'b0;
            for (int i = 0; i <= SQ_N; i++)
            begin
                sq_v_reg[i] <= 1'b0;
            end
            for (int j = 0; j <= DV_N; j++)
            begin
                dv_v_reg[j] <= 1'b0;
            end
            o_v_reg <= 1'b0;
        end
        else if (en)
        begin
            a_v_reg     <= in_valid;
            b_v_reg     <= a_v_reg;
            c_v_reg     <= b_v_reg;
            d_v_reg     <= c_v_reg;
            e_v_reg     <= d_v_reg;
            sq_v_reg[0] <= e_v_reg;
            for (int i = 0; i < SQ_N; i++)
            begin
                sq_v_reg[i+1] <= sq_v_reg[i];
            end
            dv_v_reg[0] <= sq_v_reg[SQ_N];
            for (int j = 0; j < DV_N; j++)
            begin
                dv_v_reg[j+1] <= dv_v_reg[j];
            end
            o_v_reg <= dv_v_reg[DV_N];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_neg_reg   <= neg_next;
            b_neg_reg   <= a_neg_reg;
            b_max_reg   <= max_next;
            c_neg_reg   <= b_neg_reg;
            c_msb_reg   <= msb_next;
            c_zero_reg  <= (b_max_reg == '0);
            d_neg_reg   <= c_neg_reg;
            d_zero_reg  <= c_zero_reg;
            e_neg_reg   <= d_neg_reg;
            e_zero_reg  <= d_zero_reg;
            for (int k = 0; k < 3; k++)
            begin
                a_mag_reg[k] <= mag_next[k];
                b_mag_reg[k] <= a_mag_reg[k];
                c_mag_reg[k] <= b_mag_reg[k];
                d_u_reg[k]   <= shift_tmp[k][NW-1:0];
                e_sq_reg[k]  <= d_u_reg[k] * d_u_reg[k];
                e_u_reg[k]   <= d_u_reg[k];
                sq_u_reg[0][k] <= e_u_reg[k];
            end
            sq_rem_reg[0]  <= SW'(e_sq_reg[0]) + SW'(e_sq_reg[1]) + SW'(e_sq_reg[2]);
            sq_res_reg[0]  <= '0;
            sq_neg_reg[0]  <= e_neg_reg;
            sq_zero_reg[0] <= e_zero_reg;
            for (int i = 0; i < SQ_N; i++)
            begin
                sq_rem_reg[i+1]  <= sq_rem_next[i];
                sq_res_reg[i+1]  <= sq_res_next[i];
                sq_neg_reg[i+1]  <= sq_neg_reg[i];
                sq_zero_reg[i+1] <= sq_zero_reg[i];
                for (int k = 0; k < 3; k++)
                begin
                    sq_u_reg[i+1][k] <= sq_u_reg[i][k];
                end
            end
            dv_r_reg[0]    <= sq_res_reg[SQ_N][RW-1:0];
            dv_neg_reg[0]  <= sq_neg_reg[SQ_N];
            dv_zero_reg[0] <= sq_zero_reg[SQ_N];
            for (int k = 0; k < 3; k++)
            begin
                dv_rem_reg[0][k] <= DW'(sq_u_reg[SQ_N][k]) << FRAC;
                dv_q_reg[0][k]   <= '0;
            end
            for (int j = 0; j < DV_N; j++)
            begin
                dv_r_reg[j+1]    <= dv_r_reg[j];
                dv_neg_reg[j+1]  <= dv_neg_reg[j];
                dv_zero_reg[j+1] <= dv_zero_reg[j];
                for (int k = 0; k < 3; k++)
                begin
                    dv_rem_reg[j+1][k] <= dv_rem_next[j][k];
                    dv_q_reg[j+1][k]   <= dv_q_next[j][k];
                end
            end
            for (int k = 0; k < 3; k++)
            begin
                n_reg[k] <= n_next[k];
            end
        end
    end

    assign out_valid = o_v_reg;
    assign n         = n_reg;

endmodule

>>> hw/rtl/qwf_cross.sv
`timescale 1ns / 1ps

module qwf_cross #(
    parameter int FRAC = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic                   in_valid,
    input  logic signed [FRAC+1:0] ea [3],
    input  logic signed [FRAC+1:0] eb [3],
    input  logic signed [FRAC+1:0] ec [3],
    input  logic signed [FRAC+1:0] ed [3],
    output logic                   out_valid,
    output logic signed [FRAC+4:0] sum [3]
);
    localparam int UW = FRAC + 2;
    localparam int SUW = FRAC + 5;

    logic signed [UW-1:0]   lhs [4][3];
    logic signed [UW-1:0]   rhs [4][3];
    logic signed [2*UW-1:0] prod [4][6];
    logic signed [UW-1:0]   t_reg [4][6];
    logic                   t_v_reg;
    logic signed [SUW-1:0]  sum_next [3];
    logic signed [SUW-1:0]  sum_reg [3];
    logic                   s_v_reg;

    always_comb
    begin
        lhs[0] = ea;
        rhs[0] = ed;
        lhs[1] = ea;
        rhs[1] = eb;
        lhs[2] = eb;
        rhs[2] = ec;
        lhs[3] = ec;
        rhs[3] = ed;
        for (int i = 0; i < 4; i++)
        begin
            prod[i][0] = lhs[i][1] * rhs[i][2];
            prod[i][1] = lhs[i][2] * rhs[i][1];
            prod[i][2] = lhs[i][2] * rhs[i][0];
            prod[i][3] = lhs[i][0] * rhs[i][2];
            prod[i][4] = lhs[i][0] * rhs[i][1];
            prod[i][5] = lhs[i][1] * rhs[i][0];
        end
        for (int k = 0; k < 3; k++)
        begin
            sum_next[k] = '0;
            for (int i = 0; i < 4; i++)
            begin
                sum_next[k] = sum_next[k] + SUW'(t_reg[i][2*k]) - SUW'(t_reg[i][2*k+1]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t_v_reg <= 1'b0;
            s_v_reg <= 1'b0;
        end
        else if (en)
        begin
            t_v_reg <= in_valid;
            s_v_reg <= t_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 4; i++)
            begin
                for (int m = 0; m < 6; m++)
                begin
                    t_reg[i][m] <= $signed(prod[i][m][FRAC+UW-1:FRAC]);
                end
            end
            sum_reg <= sum_next;
        end
    end

    assign out_valid = s_v_reg;
    assign sum       = sum_reg;

endmodule

>>> hw/rtl/qwf_force.sv
`timescale 1ns / 1ps

module qwf_force #(
    parameter int FRAC        = 16,
    parameter int COORD_WIDTH = 32
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 en,
    input  logic                                 in_valid,
    input  logic signed [FRAC+1:0]               n [3],
    input  logic signed [qwf_pkg::CFG_W-1:0]     w [3],
    input  logic signed [qwf_pkg::CFG_W-1:0]     strength,
    output logic                                 out_valid,
    output logic signed [COORD_WIDTH-1:0]        f [3]
);
    localparam int CW  = qwf_pkg::CFG_W;
    localparam int UW  = FRAC + 2;
    localparam int TW  = CW + 1;
    localparam int DTW = CW + 3;
    localparam int KPW = DTW + CW;
    localparam int KW  = KPW - FRAC;
    localparam int WF  = KW + CW;
    localparam int FW  = WF - FRAC;
    localparam int MW  = ((FW > COORD_WIDTH) ? FW : COORD_WIDTH) + 1;

    logic signed [UW+CW-1:0] tp [3];
    logic signed [TW-1:0]    t_reg [3];
    logic signed [DTW-1:0]   dot_reg;
    logic signed [KPW-1:0]   kp;
    logic signed [KW-1:0]    k_reg;
    logic signed [CW+32:0]   plo_reg [3];
    logic signed [KW-1:0]    phi_reg [3];
    logic signed [WF-1:0]    full [3];
    logic signed [FW-1:0]    fr_reg [3];
    logic signed [MW-1:0]    fe [3];
    logic signed [MW-1:0]    sat_hi;
    logic signed [MW-1:0]    sat_lo;
    logic signed [COORD_WIDTH-1:0] f_next [3];
    logic signed [COORD_WIDTH-1:0] f_reg [3];
    logic [5:0]              v_reg;

    always_comb
    begin
        sat_hi = $signed({{(MW-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}});
        sat_lo = ~sat_hi;
        kp = KPW'(dot_reg) * KPW'(strength);
        for (int k = 0; k < 3; k++)
        begin
            tp[k]   = (UW+CW)'(n[k]) * (UW+CW)'(w[k]);
            full[k] = (WF'(phi_reg[k]) <<< CW) + WF'(plo_reg[k]);
            fe[k]   = MW'(fr_reg[k]);
            if (fe[k] > sat_hi)
            begin
                f_next[k] = sat_hi[COORD_WIDTH-1:0];
            end
            else if (fe[k] < sat_lo)
            begin
                f_next[k] = sat_lo[COORD_WIDTH-1:0];
            end
            else
            begin
                f_next[k] = fe[k][COORD_WIDTH-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[4:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                t_reg[k]   <= $signed(tp[k][FRAC+TW-1:FRAC]);
                plo_reg[k] <= $signed({1'b0, k_reg[CW-1:0]}) * w[k];
                phi_reg[k] <= $signed(k_reg[KW-1:CW]) * w[k];
                fr_reg[k]  <= $signed(full[k][WF-1:FRAC]);
                f_reg[k]   <= f_next[k];
            end
            dot_reg <= DTW'(t_reg[0]) + DTW'(t_reg[1]) + DTW'(t_reg[2]);
            k_reg   <= $signed(kp[KPW-1:FRAC]);
        end
    end

    assign out_valid = v_reg[5];
    assign f         = f_reg;

endmodule

>>> hw/rtl/quad_wind_force.sv
`timescale 1ns / 1ps

// Wind force on one cloth quad, signed fixed point with FRAC_BITS fraction bits.
// quad: request of four corner positions; result: request of one force vector.
// Wind direction and strength are set through the write port (cfg_we,
// cfg_index, cfg_wdata); the user must write only while no quad is in flight,
// which the block itself does not enforce. One quad is taken every cycle while
// quad.ready is high. The pipeline depth is set mostly by the two normalisers
// in series, each a bit-per-stage square root of 32 stages followed by a
// bit-per-stage divider of FRAC_BITS+1 stages.
// Reset clears all valid bits and sets the wind registers to zero.
// When the receiver holds ready low with a result waiting, the whole pipeline
// holds and quad.ready drops; nothing is lost or repeated. The final stage is
// the output register.
module quad_wind_force #(
    parameter int FRAC_BITS   = 16,
    parameter int COORD_WIDTH = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [qwf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [qwf_pkg::CFG_W-1:0]         cfg_wdata,
    qwf_in_if.sink                            quad,
    qwf_out_if.source                         result
);
    localparam int EW  = COORD_WIDTH + 1;
    localparam int UW  = FRAC_BITS + 2;
    localparam int SUW = FRAC_BITS + 5;

    logic signed [qwf_pkg::CFG_W-1:0] wind_reg [3];
    logic signed [qwf_pkg::CFG_W-1:0] strength_reg;

    logic en;
    logic take;
    logic signed [EW-1:0]  da [3];
    logic signed [EW-1:0]  db [3];
    logic signed [EW-1:0]  dc [3];
    logic signed [EW-1:0]  dd [3];
    logic signed [UW-1:0]  ua [3];
    logic signed [UW-1:0]  ub [3];
    logic signed [UW-1:0]  uc [3];
    logic signed [UW-1:0]  ud [3];
    logic                  va, vb, vc, vd;
    logic signed [SUW-1:0] sum [3];
    logic                  v_sum;
    logic signed [UW-1:0]  nrm [3];
    logic                  v_nrm;
    logic signed [COORD_WIDTH-1:0] fv [3];
    logic                  v_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wind_reg[0]  <= '0;
            wind_reg[1]  <= '0;
            wind_reg[2]  <= '0;
            strength_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (qwf_pkg::cfg_idx_t'(cfg_index))
                qwf_pkg::CFG_WIND_DIR_X:    wind_reg[0]  <= $signed(cfg_wdata);
                qwf_pkg::CFG_WIND_DIR_Y:    wind_reg[1]  <= $signed(cfg_wdata);
                qwf_pkg::CFG_WIND_DIR_Z:    wind_reg[2]  <= $signed(cfg_wdata);
                qwf_pkg::CFG_WIND_STRENGTH: strength_reg <= $signed(cfg_wdata);
                default:                    strength_reg <= strength_reg;
            endcase
        end
    end

    assign en         = !v_out || result.ready;
    assign quad.ready = en;
    assign take       = quad.valid;

    always_comb
    begin
        da[0] = EW'(quad.p2_x) - EW'(quad.p1_x);
        da[1] = EW'(quad.p2_y) - EW'(quad.p1_y);
        da[2] = EW'(quad.p2_z) - EW'(quad.p1_z);
        db[0] = EW'(quad.p3_x) - EW'(quad.p2_x);
        db[1] = EW'(quad.p3_y) - EW'(quad.p2_y);
        db[2] = EW'(quad.p3_z) - EW'(quad.p2_z);
        dc[0] = EW'(quad.p4_x) - EW'(quad.p3_x);
        dc[1] = EW'(quad.p4_y) - EW'(quad.p3_y);
        dc[2] = EW'(quad.p4_z) - EW'(quad.p3_z);
        dd[0] = EW'(quad.p4_x) - EW'(quad.p1_x);
        dd[1] = EW'(quad.p4_y) - EW'(quad.p1_y);
        dd[2] = EW'(quad.p4_z) - EW'(quad.p1_z);
    end

    qwf_norm #(.IN_W(EW), .FRAC(FRAC_BITS)) u_norm_a (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(take), .c(da),
        .out_valid(va), .n(ua));
    qwf_norm #(.IN_W(EW), .FRAC(FRAC_BITS)) u_norm_b (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(take), .c(db),
        .out_valid(vb), .n(ub));
    qwf_norm #(.IN_W(EW), .FRAC(FRAC_BITS)) u_norm_c (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(take), .c(dc),
        .out_valid(vc), .n(uc));
    qwf_norm #(.IN_W(EW), .FRAC(FRAC_BITS)) u_norm_d (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(take), .c(dd),
        .out_valid(vd), .n(ud));

    qwf_cross #(.FRAC(FRAC_BITS)) u_cross (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(va & vb & vc & vd),
        .ea(ua), .eb(ub), .ec(uc), .ed(ud), .out_valid(v_sum), .sum(sum));

    qwf_norm #(.IN_W(SUW), .FRAC(FRAC_BITS)) u_norm_n (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(v_sum), .c(sum),
        .out_valid(v_nrm), .n(nrm));

    qwf_force #(.FRAC(FRAC_BITS), .COORD_WIDTH(COORD_WIDTH)) u_force (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(v_nrm), .n(nrm),
        .w(wind_reg), .strength(strength_reg), .out_valid(v_out), .f(fv));

    assign result.valid   = v_out;
    assign result.force_x = fv[0];
    assign result.force_y = fv[1];
    assign result.force_z = fv[2];

endmodule

>>> verif/qwf_checker.sv
`timescale 1ns / 1ps

module qwf_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [qwf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [qwf_pkg::CFG_W-1:0]     cfg_wdata,
    qwf_in_if                             quad,
    qwf_out_if                            result,
    output int                            errors,
    output int                            pending,
    output int                            n_forces
);
    localparam int FRAC = 16;
    localparam logic signed [127:0] I64_MAX = 128'sh7fffffffffffffff;
    localparam logic signed [127:0] I64_MIN = -I64_MAX - 1;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } force_t;

    force_t expected_forces[$];
    logic signed [31:0] wind_dir[3];
    logic signed [31:0] wind_strength;

    // floor(a*b / 2^FRAC), clamped to 64 bits
    function automatic longint mul_fix(longint a, longint b);
        logic signed [127:0] pa;
        logic signed [127:0] pb;
        logic signed [127:0] p;
        pa = a;
        pb = b;
        p = (pa * pb) >>> FRAC;
        if (p > I64_MAX)
            return longint'(I64_MAX[63:0]);
        if (p < I64_MIN)
            return longint'(I64_MIN[63:0]);
        return longint'(p[63:0]);
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] s);
        logic [63:0] res;
        logic [63:0] bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > s)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (s >= res + bitv)
            begin
                s = s - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    task automatic unit_vec(input longint c[3], output longint n[3]);
        logic [63:0] u[3];
        logic [63:0] m;
        logic [63:0] s;
        logic [63:0] r;
        int msb;
        m = 0;
        msb = 0;
        for (int i = 0; i < 3; i++)
        begin
            u[i] = c[i] < 0 ? 64'd0 - 64'(c[i]) : 64'(c[i]);
            if (u[i] > m)
                m = u[i];
        end
        if (m == 0)
        begin
            for (int i = 0; i < 3; i++)
                n[i] = 0;
            return;
        end
        while ((m >> msb) > 1)
            msb++;
        for (int i = 0; i < 3; i++)
            u[i] = msb > 29 ? u[i] >> (msb - 29) : u[i] << (29 - msb);
        s = u[0] * u[0] + u[1] * u[1] + u[2] * u[2];
        r = int_sqrt(s);
        for (int i = 0; i < 3; i++)
        begin
            longint q;
            q = longint'((u[i] << FRAC) / r);
            n[i] = c[i] < 0 ? -q : q;
        end
    endtask

    task automatic edge_unit(input longint a[3], input longint b[3], output longint n[3]);
        longint d[3];
        for (int i = 0; i < 3; i++)
            d[i] = b[i] - a[i];
        unit_vec(d, n);
    endtask

    task automatic add_cross(input longint a[3], input longint b[3], inout longint acc[3]);
        acc[0] += mul_fix(a[1], b[2]) - mul_fix(a[2], b[1]);
        acc[1] += mul_fix(a[2], b[0]) - mul_fix(a[0], b[2]);
        acc[2] += mul_fix(a[0], b[1]) - mul_fix(a[1], b[0]);
    endtask

    function automatic logic signed [31:0] clamp32(longint v);
        if (v > 64'sd2147483647)
            return 32'sh7fffffff;
        if (v < -64'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    task automatic wind_force(output force_t f);
        longint p1[3], p2[3], p3[3], p4[3];
        longint ea[3], eb[3], ec[3], ed[3], nsum[3], n[3], w[3];
        longint dot, k;
        p1 = '{longint'(quad.p1_x), longint'(quad.p1_y), longint'(quad.p1_z)};
        p2 = '{longint'(quad.p2_x), longint'(quad.p2_y), longint'(quad.p2_z)};
        p3 = '{longint'(quad.p3_x), longint'(quad.p3_y), longint'(quad.p3_z)};
        p4 = '{longint'(quad.p4_x), longint'(quad.p4_y), longint'(quad.p4_z)};
        for (int i = 0; i < 3; i++)
        begin
            w[i] = longint'(wind_dir[i]);
            nsum[i] = 0;
        end
        edge_unit(p1, p2, ea);
        edge_unit(p2, p3, eb);
        edge_unit(p3, p4, ec);
        edge_unit(p1, p4, ed);
        add_cross(ea, ed, nsum);
        add_cross(ea, eb, nsum);
        add_cross(eb, ec, nsum);
        add_cross(ec, ed, nsum);
        unit_vec(nsum, n);
        dot = mul_fix(n[0], w[0]) + mul_fix(n[1], w[1]) + mul_fix(n[2], w[2]);
        k = mul_fix(dot, longint'(wind_strength));
        f.x = clamp32(mul_fix(k, w[0]));
        f.y = clamp32(mul_fix(k, w[1]));
        f.z = clamp32(mul_fix(k, w[2]));
    endtask

    task automatic report(string what, logic [31:0] exp_v, logic [31:0] got_v);
        $display("tb: mismatch on %s: expected %h, got %h at %0t", what, exp_v, got_v, $realtime);
        errors++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wind_dir[0] <= 0;
            wind_dir[1] <= 0;
            wind_dir[2] <= 0;
            wind_strength <= 0;
            expected_forces.delete();
            pending <= 0;
            n_forces <= 0;
        end
        else
        begin
            force_t f;
            force_t got;
            if (cfg_we)
            begin
                case (qwf_pkg::cfg_idx_t'(cfg_index))
                    qwf_pkg::CFG_WIND_DIR_X:    wind_dir[0] <= cfg_wdata;
                    qwf_pkg::CFG_WIND_DIR_Y:    wind_dir[1] <= cfg_wdata;
                    qwf_pkg::CFG_WIND_DIR_Z:    wind_dir[2] <= cfg_wdata;
                    qwf_pkg::CFG_WIND_STRENGTH: wind_strength <= cfg_wdata;
                    default: ;
                endcase
            end
            if (quad.valid && quad.ready)
            begin
                wind_force(f);
                expected_forces.push_back(f);
            end
            if (result.valid && result.ready)
            begin
                got.x = result.force_x;
                got.y = result.force_y;
                got.z = result.force_z;
                if (expected_forces.size() == 0)
                begin
                    $display("tb: unexpected force request at %0t", $realtime);
                    errors++;
                end
                else
                begin
                    f = expected_forces.pop_front();
                    if (got.x !== f.x)
                        report("force_x", f.x, got.x);
                    if (got.y !== f.y)
                        report("force_y", f.y, got.y);
                    if (got.z !== f.z)
                        report("force_z", f.z, got.z);
                end
                n_forces <= n_forces + 1;
            end
            pending <= expected_forces.size();
        end
    end

    initial
        errors = 0;
endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    localparam int LATENCY   = 122;
    localparam int LIMIT     = 400000;
    localparam int LONG_HOLD = 400;

    typedef logic signed [31:0] corners_t[12];

    logic                          clk;
    logic                          rst_n;
    logic                          cfg_we;
    logic [qwf_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [qwf_pkg::CFG_W-1:0]     cfg_wdata;
    int                   errors;
    int                   pending;
    int                   n_forces;
    int                   cycles;
    bit                   calm;
    bit                   hold_done;
    int                   n_quads;

    qwf_in_if  #(.COORD_WIDTH(32)) quad_ch ();
    qwf_out_if #(.COORD_WIDTH(32)) force_ch ();

    quad_wind_force #(.FRAC_BITS(16), .COORD_WIDTH(32)) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .quad      (quad_ch),
        .result    (force_ch)
    );

    qwf_checker i_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .quad      (quad_ch),
        .result    (force_ch),
        .errors    (errors),
        .pending   (pending),
        .n_forces  (n_forces)
    );

    initial
        clk = 0;

    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic int draw_gap();
        if (calm)
            return 0;
        return $urandom_range(0, 11);
    endfunction

    // receiver: random stalls, one long hold once the pipeline is busy
    initial
    begin
        int gap;
        force_ch.ready = 0;
        @(posedge rst_n);
        forever
        begin
            gap = draw_gap();
            if (!hold_done && n_quads > 300)
            begin
                hold_done = 1;
                gap = LONG_HOLD;
            end
            if (gap > 0)
            begin
                force_ch.ready <= 0;
                repeat (gap) @(posedge clk);
            end
            force_ch.ready <= 1;
            @(posedge clk);
            while (!force_ch.valid)
                @(posedge clk);
        end
    end

    task automatic write_wind(logic [31:0] wx, logic [31:0] wy, logic [31:0] wz,
                              logic [31:0] ws);
        cfg_we <= 1;
        cfg_index <= qwf_pkg::CFG_WIND_DIR_X;
        cfg_wdata <= wx;
        @(posedge clk);
        cfg_index <= qwf_pkg::CFG_WIND_DIR_Y;
        cfg_wdata <= wy;
        @(posedge clk);
        cfg_index <= qwf_pkg::CFG_WIND_DIR_Z;
        cfg_wdata <= wz;
        @(posedge clk);
        cfg_index <= qwf_pkg::CFG_WIND_STRENGTH;
        cfg_wdata <= ws;
        @(posedge clk);
        cfg_we <= 0;
        @(posedge clk);
    endtask

    task automatic send_quad(corners_t c);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            quad_ch.valid <= 0;
            repeat (gap) @(posedge clk);
        end
        quad_ch.valid <= 1;
        quad_ch.p1_x <= c[0];
        quad_ch.p1_y <= c[1];
        quad_ch.p1_z <= c[2];
        quad_ch.p2_x <= c[3];
        quad_ch.p2_y <= c[4];
        quad_ch.p2_z <= c[5];
        quad_ch.p3_x <= c[6];
        quad_ch.p3_y <= c[7];
        quad_ch.p3_z <= c[8];
        quad_ch.p4_x <= c[9];
        quad_ch.p4_y <= c[10];
        quad_ch.p4_z <= c[11];
        @(posedge clk);
        while (!quad_ch.ready)
            @(posedge clk);
        n_quads++;
    endtask

    task automatic drain();
        quad_ch.valid <= 0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (LATENCY + 8) @(posedge clk);
    endtask

    task automatic fill(output corners_t c, input logic signed [31:0] v);
        for (int i = 0; i < 12; i++)
            c[i] = v;
    endtask

    // random quad: mostly a plausible patch near a base point, some raw noise
    task automatic random_quad(output corners_t c);
        int sel;
        int span;
        logic signed [31:0] base;
        sel = $urandom_range(0, 9);
        span = $urandom_range(4, 26);
        for (int i = 0; i < 12; i++)
        begin
            if (sel == 0)
                c[i] = $urandom;
            else
            begin
                if (i < 3)
                    c[i] = $signed($urandom) >>> $urandom_range(1, 8);
                else
                    c[i] = c[i % 3] + ($signed($urandom) >>> (32 - span));
            end
        end
        if (sel == 1)
        begin
            base = c[$urandom_range(0, 2)];
            c[3 * $urandom_range(0, 3) + $urandom_range(0, 2)] = base;
        end
        if (sel == 2)
            for (int i = 3; i < 6; i++)
                c[i] = c[i - 3];
    endtask

    task automatic random_phase(int count);
        corners_t c;
        for (int i = 0; i < count; i++)
        begin
            if (i % 64 == 0)
                calm = ($urandom_range(0, 3) == 0);
            random_quad(c);
            send_quad(c);
        end
        calm = 0;
        drain();
    endtask

    initial
    begin
        corners_t c;
        rst_n = 0;
        cycles = 0;
        calm = 0;
        hold_done = 0;
        n_quads = 0;
        cfg_we = 0;
        cfg_index = qwf_pkg::CFG_WIND_DIR_X;
        cfg_wdata = 0;
        quad_ch.valid = 0;
        quad_ch.p1_x = 0;
        quad_ch.p1_y = 0;
        quad_ch.p1_z = 0;
        quad_ch.p2_x = 0;
        quad_ch.p2_y = 0;
        quad_ch.p2_z = 0;
        quad_ch.p3_x = 0;
        quad_ch.p3_y = 0;
        quad_ch.p3_z = 0;
        quad_ch.p4_x = 0;
        quad_ch.p4_y = 0;
        quad_ch.p4_z = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // reset wind: everything yields zero force
        c = '{0, 0, 0, 32'sh10000, 0, 0, 32'sh10000, 32'sh10000, 0, 0, 32'sh10000, 0};
        send_quad(c);
        drain();

        write_wind(32'sh0, 32'sh0, 32'sh10000, 32'sh10000);
        // unit square in xy, tilted square, fully degenerate, one collapsed edge, then extreme and tiny coordinates
        send_quad(c);
        c = '{0, 0, 0, 32'sh10000, 0, 32'sh10000, 32'sh10000, 32'sh10000, 32'sh10000,
              0, 32'sh10000, 0};
        send_quad(c);
        fill(c, 32'sh12345);
        send_quad(c);
        c = '{0, 0, 0, 0, 0, 0, 32'sh10000, 32'sh10000, 0, 0, 32'sh10000, 0};
        send_quad(c);
        fill(c, 32'sh7fffffff);
        send_quad(c);
        fill(c, 32'sh80000000);
        send_quad(c);
        c = '{32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh7fffffff, 32'sh80000000,
              32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 32'sh80000000,
              32'sh7fffffff, 32'sh7fffffff};
        send_quad(c);
        c = '{0, 0, 0, 1, 0, 0, 1, 1, 0, 0, 1, 0};
        send_quad(c);
        c = '{32'sh7fffffff, 0, 0, 32'sh80000000, 0, 0, 32'sh80000000, 32'sh7fffffff, 0,
              32'sh7fffffff, 32'sh7fffffff, 32'sh80000000};
        send_quad(c);
        drain();

        // extreme wind: saturate the force
        write_wind(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff);
        c = '{0, 0, 0, 32'sh10000, 0, 32'sh8000, 32'sh10000, 32'sh10000, 32'sh10000,
              0, 32'sh10000, 32'sh4000};
        send_quad(c);
        c = '{0, 0, 0, 0, 32'sh10000, 0, 0, 32'sh10000, 32'sh10000, 0, 0, 32'sh10000};
        send_quad(c);
        random_phase(150);

        write_wind(32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000);
        random_phase(150);

        write_wind($urandom, $urandom, $urandom, $urandom >> $urandom_range(8, 20));
        random_phase(300);

        write_wind($signed($urandom) >>> 12, $signed($urandom) >>> 12,
                   $signed($urandom) >>> 12, $signed($urandom) >>> 10);
        random_phase(300);

        write_wind(32'sh10000, 32'shffff0000, 32'sh8000, 32'sh00020000);
        random_phase(140);

        $display("tb: %0d quads sent, %0d forces checked across six wind settings",
                 n_quads, n_forces);
        $display("tb: included degenerate quads, extreme coordinates and a long output hold");
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule

>>> filelist.f
hw/rtl/qwf_pkg.sv
hw/rtl/qwf_if.sv
hw/rtl/qwf_norm.sv
hw/rtl/qwf_cross.sv
hw/rtl/qwf_force.sv
hw/rtl/quad_wind_force.sv
verif/qwf_checker.sv
verif/tb_top.sv
